// File: design/jsu_pkg.sv
package jsu_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 4;
  localparam int NRES    = 4;
  localparam int IDX_W   = $clog2(NRES);
  localparam int CP_W    = 21;
  localparam int QUAD_W  = 16;
  localparam int HS_W    = 10;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [10:0] SUPP_PLANE_HI = 11'h040; // 0x10000 >> 10

  localparam logic [CP_W-1:0] MAX_1BYTE = 21'h00007F;
  localparam logic [CP_W-1:0] MAX_2BYTE = 21'h0007FF;
  localparam logic [CP_W-1:0] MAX_3BYTE = 21'h00FFFF;

  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] LEAD_4 = 8'hF0;
  localparam logic [7:0] CONT   = 8'h80;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX     = 3'd3,
    PH_WANT_BS = 3'd4,
    PH_WANT_U  = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_QUOTE    = 4'd1,
    ERR_CTRL        = 4'd2,
    ERR_BAD_ESC     = 4'd3,
    ERR_BAD_HEX     = 4'd4,
    ERR_MISSING_LOW = 4'd5,
    ERR_BAD_LOW     = 4'd6,
    ERR_LONE_LOW    = 4'd7,
    ERR_EARLY_END   = 4'd8
  } err_t;

  typedef struct packed {
    logic [IDX_W-1:0]            last;
    logic [NRES-1:0][BYTE_W-1:0] bytes;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok  = 1'b0;
      h.val = 4'd0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp <= MAX_1BYTE) begin
      u.last     = 2'd0;
      u.bytes[0] = cp[7:0];
    end else if (cp <= MAX_2BYTE) begin
      u.last     = 2'd1;
      u.bytes[0] = LEAD_2 | {3'b000, cp[10:6]};
      u.bytes[1] = CONT | {2'b00, cp[5:0]};
    end else if (cp <= MAX_3BYTE) begin
      u.last     = 2'd2;
      u.bytes[0] = LEAD_3 | {4'b0000, cp[15:12]};
      u.bytes[1] = CONT | {2'b00, cp[11:6]};
      u.bytes[2] = CONT | {2'b00, cp[5:0]};
    end else begin
      u.last     = 2'd3;
      u.bytes[0] = LEAD_4 | {5'b00000, cp[20:18]};
      u.bytes[1] = CONT | {2'b00, cp[17:12]};
      u.bytes[2] = CONT | {2'b00, cp[11:6]};
      u.bytes[3] = CONT | {2'b00, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// File: design/jsu_ifs.sv
interface jsu_in_if;
  logic                       valid;
  logic                       ready;
  logic [jsu_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic                       valid;
  logic                       ready;
  logic [jsu_pkg::BYTE_W-1:0] out_byte;
  logic [jsu_pkg::KIND_W-1:0] kind;
  logic [jsu_pkg::CODE_W-1:0] error_code;
  logic                       last_of_run;

  modport source (output valid, out_byte, kind, error_code, last_of_run, input ready);
  modport sink   (input valid, out_byte, kind, error_code, last_of_run, output ready);
endinterface

// File: design/json_string_unescape_utf8_unit.sv
// JSON string literal unescaper: raw text bytes in, UTF-8 bytes out.
// in_ch  : one transaction per text byte (in_byte), or an end-of-text marker.
// out_ch : one transaction per result: a decoded byte (kind 0), string closed
//          (kind 1) or a syntax error (kind 2, error_code set). last_of_run
//          marks the final result caused by one input transaction.
// Decode is done in the cycle an input is accepted; its results are loaded
// into a result register and appear on out_ch the next cycle.
// Throughput: one input per cycle while out_ch is ready and no input gives
// more than one result. A \u escape giving several UTF-8 bytes stalls in_ch
// until all but the last have left; the result register sends one result per
// ready cycle. Opening quotes, backslashes and leading hex digits: no result.
// in_ch.ready stays high while the result register is empty or its last
// result is being taken, so input overlaps with output.
// A stalled out_ch holds its result and, once the register is full, stops
// in_ch; nothing is dropped.
// Reset (synchronous) empties the result register and returns the decoder
// to waiting for an opening quote. After a closing quote or any error the
// decoder also returns there.
module json_string_unescape_utf8_unit (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  // decoder state
  phase_t            phase, phase_next;
  logic [1:0]        digit_count, digit_count_next;
  logic [QUAD_W-1:0] code_value, code_value_next;
  logic [HS_W-1:0]   high_surrogate, high_surrogate_next;
  logic              second_quad, second_quad_next;

  // result register
  logic                        pend_valid;
  logic [IDX_W-1:0]            pend_idx;
  logic [IDX_W-1:0]            pend_last;
  kind_t                       pend_kind;
  err_t                        pend_code;
  logic [NRES-1:0][BYTE_W-1:0] pend_bytes;

  // results of the current input
  logic                        res_valid;
  kind_t                       res_kind;
  err_t                        res_code;
  logic [IDX_W-1:0]            res_last;
  logic [NRES-1:0][BYTE_W-1:0] res_bytes;

  logic              in_fire, out_fire;
  logic [7:0]        c;
  logic              eot;
  hex_t              hx;
  logic [QUAD_W-1:0] quad;
  logic              quad_done, is_hi, is_lo;
  logic [CP_W-1:0]   pair_cp, cp_sel;
  utf8_t             enc;

  assign c   = in_ch.in_byte;
  assign eot = in_ch.end_of_text;
  assign hx  = hex_decode(c);
  assign quad = {code_value[QUAD_W-5:0], hx.val};
  assign quad_done = (digit_count == 2'd3);
  assign is_hi = (quad >= HI_SURR_MIN) && (quad <= HI_SURR_MAX);
  assign is_lo = (quad >= LO_SURR_MIN) && (quad <= LO_SURR_MAX);
  // 0x10000 + (hs << 10) + (lo - 0xDC00)
  assign pair_cp = {({1'b0, high_surrogate} + SUPP_PLANE_HI), quad[9:0]};
  assign cp_sel  = second_quad ? pair_cp : {{(CP_W-QUAD_W){1'b0}}, quad};
  assign enc     = utf8_encode(cp_sel);

  assign in_ch.ready = !pend_valid || (out_ch.ready && (pend_idx == pend_last));
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // results for the byte on in_ch
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_BYTE;
    res_code  = ERR_NONE;
    res_last  = '0;
    res_bytes = '0;
    if (eot) begin
      res_valid = 1'b1;
      res_kind  = KIND_ERROR;
      res_code  = ERR_EARLY_END;
    end else begin
      case (phase)
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            res_valid = 1'b1;
            res_kind  = KIND_DONE;
          end else if (c < CTRL_LIMIT) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_code  = ERR_CTRL;
          end else if (c != CH_BSLASH) begin
            res_valid    = 1'b1;
            res_bytes[0] = c;
          end
        end
        PH_ESC: begin
          res_valid = 1'b1;
          case (c)
            CH_QUOTE:  res_bytes[0] = CH_QUOTE;
            CH_BSLASH: res_bytes[0] = CH_BSLASH;
            CH_SLASH:  res_bytes[0] = CH_SLASH;
            CH_B:      res_bytes[0] = 8'h08;
            CH_F:      res_bytes[0] = 8'h0C;
            CH_N:      res_bytes[0] = 8'h0A;
            CH_R:      res_bytes[0] = 8'h0D;
            CH_T:      res_bytes[0] = 8'h09;
            CH_U:      res_valid = 1'b0;
            default: begin
              res_kind = KIND_ERROR;
              res_code = ERR_BAD_ESC;
            end
          endcase
        end
        PH_HEX: begin
          if (!hx.ok) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_code  = ERR_BAD_HEX;
          end else if (quad_done) begin
            if (second_quad && !is_lo) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_code  = ERR_BAD_LOW;
            end else if (!second_quad && is_lo) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_code  = ERR_LONE_LOW;
            end else if (second_quad || !is_hi) begin
              res_valid = 1'b1;
              res_last  = enc.last;
              res_bytes = enc.bytes;
            end
          end
        end
        PH_WANT_BS: begin
          if (c != CH_BSLASH) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_code  = ERR_MISSING_LOW;
          end
        end
        PH_WANT_U: begin
          if (c != CH_U) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_code  = ERR_MISSING_LOW;
          end
        end
        default: begin
          // idle, and unused codes behave as idle
          if (c != CH_QUOTE) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_code  = ERR_NO_QUOTE;
          end
        end
      endcase
    end
  end

  // next decoder state
  always_comb begin
    phase_next          = phase;
    digit_count_next    = digit_count;
    code_value_next     = code_value;
    high_surrogate_next = high_surrogate;
    second_quad_next    = second_quad;
    if (res_valid && (res_kind != KIND_BYTE)) begin
      // closing quote or error: back to waiting for a quote, all cleared
      phase_next          = PH_IDLE;
      digit_count_next    = '0;
      code_value_next     = '0;
      high_surrogate_next = '0;
      second_quad_next    = 1'b0;
    end else begin
      case (phase)
        PH_BODY: begin
          if (c == CH_BSLASH) phase_next = PH_ESC;
        end
        PH_ESC: begin
          if (c == CH_U) begin
            phase_next       = PH_HEX;
            digit_count_next = '0;
            code_value_next  = '0;
            second_quad_next = 1'b0;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_HEX: begin
          if (!quad_done) begin
            digit_count_next = digit_count + 2'd1;
            code_value_next  = quad;
          end else begin
            digit_count_next = '0;
            code_value_next  = '0;
            if (second_quad) begin
              high_surrogate_next = '0;
              second_quad_next    = 1'b0;
              phase_next          = PH_BODY;
            end else if (is_hi) begin
              high_surrogate_next = quad[HS_W-1:0];
              phase_next          = PH_WANT_BS;
            end else begin
              phase_next = PH_BODY;
            end
          end
        end
        PH_WANT_BS: phase_next = PH_WANT_U;
        PH_WANT_U: begin
          phase_next       = PH_HEX;
          digit_count_next = '0;
          code_value_next  = '0;
          second_quad_next = 1'b1;
        end
        default: phase_next = PH_BODY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      digit_count    <= '0;
      code_value     <= '0;
      high_surrogate <= '0;
      second_quad    <= 1'b0;
    end else if (in_fire) begin
      phase          <= phase_next;
      digit_count    <= digit_count_next;
      code_value     <= code_value_next;
      high_surrogate <= high_surrogate_next;
      second_quad    <= second_quad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_idx   <= '0;
    end else if (in_fire) begin
      pend_valid <= res_valid;
      pend_idx   <= '0;
    end else if (out_fire) begin
      if (pend_idx == pend_last) begin
        pend_valid <= 1'b0;
      end else begin
        pend_idx <= pend_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_last  <= res_last;
      pend_kind  <= res_kind;
      pend_code  <= res_code;
      pend_bytes <= res_bytes;
    end
  end

  assign out_ch.valid       = pend_valid;
  assign out_ch.out_byte    = pend_bytes[pend_idx];
  assign out_ch.kind        = pend_kind;
  assign out_ch.error_code  = pend_code;
  assign out_ch.last_of_run = (pend_idx == pend_last);

`ifndef SYNTHESIS
  // a new input over a full result register only when its last result leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_fire && pend_valid) |-> (out_fire && out_ch.last_of_run))
    else $error("result register overwritten");

  // close and error results stand alone
  a_single_status: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (pend_kind != KIND_BYTE)) |-> (out_ch.last_of_run && pend_idx == '0))
    else $error("status result not alone");

  // after a close or an error the decoder waits for a quote again
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid && (res_kind != KIND_BYTE)) |=>
      (phase == PH_IDLE && second_quad == 1'b0 && digit_count == '0))
    else $error("decoder not cleared after close or error");

  // error results, and only they, carry an error code
  a_code_match: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((pend_kind == KIND_ERROR) == (pend_code != ERR_NONE)))
    else $error("error code does not match kind");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import jsu_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eot;
    bit         drain;
  } text_byte_t;

  typedef struct {
    logic [7:0] out_byte;
    kind_t      kind;
    err_t       code;
    logic       last;
  } decoded_t;

  typedef enum int {
    FLT_NONE, FLT_NOISE, FLT_CTRL, FLT_ESC, FLT_HEX, FLT_NO_LOW, FLT_BAD_LOW,
    FLT_LONE_LOW, FLT_EOT, FLT_EOT_HEX
  } fault_t;

  localparam int QUIET_LIMIT = 4000;

  logic clk;
  logic rst;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_utf8_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  text_byte_t text_fifo[$];
  decoded_t   utf8_expected[$];
  bit         mark_drain = 1'b0;
  int         fail_count = 0;
  int         in_taken = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  logic       calm;

  // decoder copy
  phase_t      dec_phase;
  logic [1:0]  nib_cnt;
  logic [15:0] quad_acc;
  logic [9:0]  hi_half;
  logic        low_quad;
  decoded_t    step_res[0:3];
  int          step_n;

  // stretch with no idling on either side
  assign calm = (in_taken >= 300 && in_taken < 370);

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
    if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  task automatic add_result(input logic [7:0] b, input kind_t k, input err_t e);
    step_res[step_n].out_byte = b;
    step_res[step_n].kind     = k;
    step_res[step_n].code     = e;
    step_res[step_n].last     = 1'b0;
    step_n++;
  endtask

  task automatic clear_decoder();
    dec_phase = PH_IDLE;
    nib_cnt   = '0;
    quad_acc  = '0;
    hi_half   = '0;
    low_quad  = 1'b0;
  endtask

  task automatic decode_error(input err_t e);
    clear_decoder();
    add_result(8'h00, KIND_ERROR, e);
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    int          nb;
    logic [7:0]  lead;
    logic [20:0] shifted;
    if (cp < 21'h80) begin
      add_result(cp[7:0], KIND_BYTE, ERR_NONE);
    end else begin
      if (cp < 21'h800) begin
        nb = 2; lead = 8'hC0;
      end else if (cp < 21'h10000) begin
        nb = 3; lead = 8'hE0;
      end else begin
        nb = 4; lead = 8'hF0;
      end
      shifted = cp >> (6 * (nb - 1));
      add_result(lead | shifted[7:0], KIND_BYTE, ERR_NONE);
      for (int i = nb - 2; i >= 0; i--) begin
        shifted = cp >> (6 * i);
        add_result({2'b10, shifted[5:0]}, KIND_BYTE, ERR_NONE);
      end
    end
  endtask

  // Works out the results of one accepted input transaction.
  task automatic decode_text_byte(input logic [7:0] c, input logic eot);
    int          d;
    logic [15:0] q;
    step_n = 0;
    if (eot) begin
      decode_error(ERR_EARLY_END);
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (c != CH_QUOTE) decode_error(ERR_NO_QUOTE);
          else dec_phase = PH_BODY;
        end
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            clear_decoder();
            add_result(8'h00, KIND_DONE, ERR_NONE);
          end else if (c < CTRL_LIMIT) begin
            decode_error(ERR_CTRL);
          end else if (c == CH_BSLASH) begin
            dec_phase = PH_ESC;
          end else begin
            add_result(c, KIND_BYTE, ERR_NONE);
          end
        end
        PH_ESC: begin
          dec_phase = PH_BODY;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(c, KIND_BYTE, ERR_NONE);
            CH_B: add_result(8'h08, KIND_BYTE, ERR_NONE);
            CH_F: add_result(8'h0C, KIND_BYTE, ERR_NONE);
            CH_N: add_result(8'h0A, KIND_BYTE, ERR_NONE);
            CH_R: add_result(8'h0D, KIND_BYTE, ERR_NONE);
            CH_T: add_result(8'h09, KIND_BYTE, ERR_NONE);
            CH_U: begin
              dec_phase = PH_HEX;
              nib_cnt   = '0;
              quad_acc  = '0;
              low_quad  = 1'b0;
            end
            default: decode_error(ERR_BAD_ESC);
          endcase
        end
        PH_HEX: begin
          d = nibble_of(c);
          if (d < 0) begin
            decode_error(ERR_BAD_HEX);
          end else begin
            q = {quad_acc[11:0], d[3:0]};
            if (nib_cnt != 2'd3) begin
              nib_cnt++;
              quad_acc = q;
            end else begin
              nib_cnt  = '0;
              quad_acc = '0;
              if (low_quad) begin
                if (q < LO_SURR_MIN || q > LO_SURR_MAX) begin
                  decode_error(ERR_BAD_LOW);
                end else begin
                  dec_phase = PH_BODY;
                  low_quad  = 1'b0;
                  emit_code_point(21'h10000 + {1'b0, hi_half, q[9:0]});
                  hi_half   = '0;
                end
              end else if (q >= HI_SURR_MIN && q <= HI_SURR_MAX) begin
                hi_half   = q[9:0];
                dec_phase = PH_WANT_BS;
              end else if (q >= LO_SURR_MIN && q <= LO_SURR_MAX) begin
                decode_error(ERR_LONE_LOW);
              end else begin
                dec_phase = PH_BODY;
                emit_code_point({5'b0, q});
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (c != CH_BSLASH) decode_error(ERR_MISSING_LOW);
          else dec_phase = PH_WANT_U;
        end
        PH_WANT_U: begin
          if (c != CH_U) begin
            decode_error(ERR_MISSING_LOW);
          end else begin
            dec_phase = PH_HEX;
            nib_cnt   = '0;
            quad_acc  = '0;
            low_quad  = 1'b1;
          end
        end
        default: clear_decoder();
      endcase
    end
    for (int i = 0; i < step_n; i++) begin
      step_res[i].last = (i == step_n - 1);
      utf8_expected.insert(utf8_expected.size(), step_res[i]);
    end
  endtask

  // ---------------- stimulus builders ----------------

  task automatic push_text(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t.data     = b;
    t.eot      = eot;
    t.drain    = mark_drain;
    mark_drain = 1'b0;
    text_fifo.insert(text_fifo.size(), t);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return 8'h30 + n;
    base = ($urandom_range(1) != 0) ? 8'h41 : 8'h61;
    return base + n - 8'd10;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B || c == CH_F
        || c == CH_N || c == CH_R || c == CH_T || c == CH_U;
  endfunction

  task automatic add_quad(input logic [15:0] v);
    push_text(CH_BSLASH, 1'b0);
    push_text(CH_U, 1'b0);
    push_text(hex_char(v[15:12]), 1'b0);
    push_text(hex_char(v[11:8]), 1'b0);
    push_text(hex_char(v[7:4]), 1'b0);
    push_text(hex_char(v[3:0]), 1'b0);
  endtask

  task automatic add_partial_quad();
    int n;
    push_text(CH_BSLASH, 1'b0);
    push_text(CH_U, 1'b0);
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) push_text(hex_char(4'($urandom_range(15))), 1'b0);
  endtask

  task automatic add_segment();
    logic [7:0]  b;
    logic [15:0] v;
    logic [7:0]  esc_set[8];
    esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    case ($urandom_range(5))
      0, 1: begin
        do b = 8'($urandom_range(8'hFF, 8'h20)); while (b == CH_QUOTE || b == CH_BSLASH);
        push_text(b, 1'b0);
      end
      2: begin
        push_text(CH_BSLASH, 1'b0);
        push_text(esc_set[$urandom_range(7)], 1'b0);
      end
      3: begin
        case ($urandom_range(3))
          0: v = 16'($urandom_range(16'h7F, 16'h0));
          1: v = 16'($urandom_range(16'h7FF, 16'h80));
          2: v = 16'($urandom_range(16'hD7FF, 16'h800));
          default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
        endcase
        add_quad(v);
      end
      default: begin
        add_quad(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
        add_quad(16'($urandom_range(LO_SURR_MAX, LO_SURR_MIN)));
      end
    endcase
  endtask

  task automatic add_fault(input fault_t f);
    logic [7:0]  b;
    logic [15:0] v;
    case (f)
      FLT_CTRL: push_text(8'($urandom_range(8'h1F, 8'h00)), 1'b0);
      FLT_ESC: begin
        do b = 8'($urandom_range(255)); while (is_escape_letter(b));
        push_text(CH_BSLASH, 1'b0);
        push_text(b, 1'b0);
      end
      FLT_HEX: begin
        do b = 8'($urandom_range(255)); while (nibble_of(b) >= 0);
        add_partial_quad();
        push_text(b, 1'b0);
      end
      FLT_NO_LOW: begin
        add_quad(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
        if ($urandom_range(1) != 0) begin
          do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
          push_text(b, 1'b0);
        end else begin
          do b = 8'($urandom_range(255)); while (b == CH_U);
          push_text(CH_BSLASH, 1'b0);
          push_text(b, 1'b0);
        end
      end
      FLT_BAD_LOW: begin
        do v = 16'($urandom_range(16'hFFFF, 16'h0));
        while (v >= LO_SURR_MIN && v <= LO_SURR_MAX);
        add_quad(16'($urandom_range(HI_SURR_MAX, HI_SURR_MIN)));
        add_quad(v);
      end
      FLT_LONE_LOW: add_quad(16'($urandom_range(LO_SURR_MAX, LO_SURR_MIN)));
      FLT_EOT: push_text(8'($urandom_range(255)), 1'b1);
      FLT_EOT_HEX: begin
        add_partial_quad();
        push_text(8'($urandom_range(255)), 1'b1);
      end
      default: ;
    endcase
  endtask

  // One string literal: mostly well formed, some broken part way through.
  task automatic add_random_string();
    fault_t     f;
    int         segs;
    int         at;
    logic [7:0] b;
    f = ($urandom_range(99) < 30) ? fault_t'($urandom_range(FLT_EOT_HEX, FLT_NOISE))
                                  : FLT_NONE;
    if (f == FLT_NOISE) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      push_text(b, 1'b0);
      f = FLT_NONE;
    end
    segs = $urandom_range(6);
    at   = $urandom_range(segs);
    push_text(CH_QUOTE, 1'b0);
    for (int k = 0; k < segs; k++) begin
      if (f != FLT_NONE && k == at) begin
        add_fault(f);
        return;
      end
      add_segment();
    end
    if (f != FLT_NONE) add_fault(f);
    else push_text(CH_QUOTE, 1'b0);
  endtask

  // ---------------- clock, reset, stimulus ----------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : stimulus
    bit drain_armed;
    drain_armed           = 1'b0;
    rst                   = 1'b1;
    in_ch.valid           = 1'b0;
    in_ch.in_byte         = '0;
    in_ch.end_of_text     = 1'b0;
    out_ch.ready          = 1'b0;
    clear_decoder();

    // directed: end of text while idle, stray byte, byte extremes, \u0000,
    // surrogate pair to four bytes, raw control byte
    push_text(8'hA5, 1'b1);
    push_text("x", 1'b0);
    push_text(CH_QUOTE, 1'b0);
    push_text(8'h20, 1'b0);
    push_text(8'hFF, 1'b0);
    add_quad(16'h0000);
    add_quad(16'hDBFF);
    add_quad(16'hDFFF);
    push_text(CH_QUOTE, 1'b0);
    push_text(CH_QUOTE, 1'b0);
    push_text(8'h1F, 1'b0);

    while (text_fifo.size() < 410) begin
      if (!drain_armed && text_fifo.size() >= 200) begin
        mark_drain  = 1'b1;
        drain_armed = 1'b1;
      end
      add_random_string();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (text_fifo.size() != 0 || in_ch.valid || utf8_expected.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // ---------------- driver ----------------

  always @(posedge clk) begin : drive_text
    text_byte_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_text_byte(in_ch.in_byte, in_ch.end_of_text);
        in_taken <= in_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        // a drain-marked transaction waits until all results are back
        if (text_fifo.size() != 0 && !(text_fifo[0].drain && utf8_expected.size() != 0)
            && (calm || $urandom_range(99) >= 11)) begin
          nxt = text_fifo.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.in_byte     <= nxt.data;
          in_ch.end_of_text <= nxt.eot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ready, with one long hold-off ----------------

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (!hold_done && in_taken >= 150) begin
      hold_left    <= 90;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : check_utf8
    decoded_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (utf8_expected.size() == 0) begin
        $display("%0t: unexpected result byte=%h kind=%0d code=%0d last=%b", $time,
                 out_ch.out_byte, out_ch.kind, out_ch.error_code, out_ch.last_of_run);
        fail_count++;
      end else begin
        want = utf8_expected.pop_front();
        if (out_ch.out_byte !== want.out_byte || out_ch.kind !== want.kind
            || out_ch.error_code !== want.code || out_ch.last_of_run !== want.last) begin
          $display({"%0t: mismatch expected byte=%h kind=%0d code=%0d last=%b,",
                    " got byte=%h kind=%0d code=%0d last=%b"},
                   $time, want.out_byte, want.kind, want.code, want.last,
                   out_ch.out_byte, out_ch.kind, out_ch.error_code, out_ch.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, utf8_expected.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// File: files.f
design/jsu_pkg.sv
design/jsu_ifs.sv
design/json_string_unescape_utf8_unit.sv
dv/tb_top.sv
